>>> rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int COUNT_OUT_W = 5;

    localparam int S_TDATA_W = ((DATA_W + PRIO_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * DATA_W + PRIO_W + COUNT_OUT_W + 1;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_INS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic                     valid;
        logic [DATA_W-1:0]        data;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic                     ins;
        logic                     pop;
        logic [DATA_W-1:0]        data;
        logic signed [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

>>> rtl/spq_cell.sv
// one storage cell of the sorted queue row
module spq_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  spq_pkg::cmd_t  cmd,
    input  logic           head_cell,
    input  logic           flag_in,
    input  spq_pkg::entry_t left_entry,
    input  spq_pkg::entry_t right_entry,
    output spq_pkg::entry_t entry,
    output spq_pkg::entry_t entry_next,
    output logic           flag_out
);

    logic                             valid_reg, valid_next;
    logic [spq_pkg::DATA_W-1:0]       data_reg, data_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg, prio_next;

    // new item belongs at or ahead of this cell
    always_comb begin
        if (!valid_reg) begin
            flag_out = 1'b1;
        end else if (head_cell) begin
            flag_out = $signed(prio_reg) < $signed(cmd.prio);
        end else begin
            flag_out = $signed(prio_reg) <= $signed(cmd.prio);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        if (cmd.ins) begin
            if (flag_in) begin
                valid_next = left_entry.valid;
                data_next  = left_entry.data;
                prio_next  = left_entry.prio;
            end else if (flag_out) begin
                valid_next = 1'b1;
                data_next  = cmd.data;
                prio_next  = cmd.prio;
            end
        end else if (cmd.pop) begin
            valid_next = right_entry.valid;
            data_next  = right_entry.data;
            prio_next  = right_entry.prio;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign entry      = '{valid: valid_reg, data: data_reg, prio: prio_reg};
    assign entry_next = '{valid: valid_next, data: data_next, prio: prio_next};

endmodule

>>> rtl/sorted_priority_queue.sv
// sorted priority queue top level: cell row, entry counter and result register
//
// A bounded queue of 16 entries kept in descending priority order in a row
// of cells, one entry per cell; every cell compares its priority with the
// incoming one in parallel and shifts toward its neighbor, so an insert or a
// pop updates the whole row at once. One item is accepted per cycle and its
// result appears in the output register on the next cycle; the input stalls
// only while that register holds a result not yet taken. The rate is set by
// the joint update of all cells of the row. On an equal priority a new item
// goes ahead of equal entries behind the front but never ahead of the front.
// A pop on an empty queue or an insert into a full queue reports an error
// status and leaves the queue unchanged.
module sorted_priority_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // item_data, item_priority
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // popped_data, head_data, head_priority, count, is_empty
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [1:0]                      m_tuser
);

    localparam int DEPTH = spq_pkg::DEPTH;

    spq_pkg::entry_t                entries [DEPTH];
    spq_pkg::entry_t                nexts   [DEPTH];
    logic [DEPTH-1:0]               flags;
    spq_pkg::cmd_t                  cmd;

    logic                           accept;
    logic                           full;
    logic                           empty;
    logic [spq_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    spq_pkg::status_t               status;
    logic [spq_pkg::DATA_W-1:0]     popped;
    logic [spq_pkg::DATA_W-1:0]     head_data;
    logic signed [spq_pkg::PRIO_W-1:0] head_prio;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [spq_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]                     m_tuser_reg, m_tuser_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = cnt_reg == spq_pkg::CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;

    always_comb begin
        cmd.ins  = accept && (s_tuser == spq_pkg::FUNC_INSERT) && !full;
        cmd.pop  = accept && (s_tuser == spq_pkg::FUNC_POP) && !empty;
        cmd.data = s_tdata[spq_pkg::DATA_W-1:0];
        cmd.prio = s_tdata[spq_pkg::DATA_W +: spq_pkg::PRIO_W];
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;
        logic            flag_in;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign flag_in    = 1'b0;
        end else begin : g_mid
            assign left_entry = entries[i-1];
            assign flag_in    = flags[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .head_cell   (i == 0),
            .flag_in     (flag_in),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .entry_next  (nexts[i]),
            .flag_out    (flags[i])
        );
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.ins) begin
            cnt_next = cnt_reg + spq_pkg::CNT_W'(1);
        end else if (cmd.pop) begin
            cnt_next = cnt_reg - spq_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        status = spq_pkg::ST_OK;
        if (s_tuser == spq_pkg::FUNC_INSERT && full) begin
            status = spq_pkg::ST_INS_FULL;
        end else if (s_tuser == spq_pkg::FUNC_POP && empty) begin
            status = spq_pkg::ST_POP_EMPTY;
        end
    end

    assign popped    = cmd.pop ? entries[0].data : '0;
    assign head_data = (cnt_next != '0) ? nexts[0].data : '0;
    assign head_prio = (cnt_next != '0) ? nexts[0].prio : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = spq_pkg::M_TDATA_W'({
                (cnt_next == '0),
                spq_pkg::COUNT_OUT_W'(cnt_next),
                head_prio,
                head_data,
                popped
            });
            m_tuser_next  = status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/spq_checker.sv
// port-level checks for the sorted priority queue
module spq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [1:0]                      m_tuser
);

    localparam int DW = spq_pkg::DATA_W;
    localparam int PW = spq_pkg::PRIO_W;
    localparam int CW = spq_pkg::COUNT_OUT_W;
    localparam int CNT_LSB = 2 * DW + PW;
    localparam int EMPTY_BIT = CNT_LSB + CW;

    logic [DW-1:0] popped;
    logic [DW-1:0] head_data;
    logic [PW-1:0] head_prio;
    logic [CW-1:0] count;
    logic          is_empty;

    assign popped    = m_tdata[DW-1:0];
    assign head_data = m_tdata[DW +: DW];
    assign head_prio = m_tdata[2*DW +: PW];
    assign count     = m_tdata[CNT_LSB +: CW];
    assign is_empty  = m_tdata[EMPTY_BIT];

    // result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty flag agrees with count and clears head fields
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (is_empty == (count == '0))
                     && (!is_empty || (head_data == '0 && head_prio == '0)))
        else $error("empty flag or head fields inconsistent");

    // an error leaves nothing popped and matches the count
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == spq_pkg::ST_POP_EMPTY |-> popped == '0 && is_empty)
        else $error("pop on empty reported with data or entries");

    a_ins_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == spq_pkg::ST_INS_FULL
            |-> popped == '0 && count == CW'(spq_pkg::DEPTH))
        else $error("insert on full reported without full count");

    // a successful pop can never leave a full queue
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == spq_pkg::ST_OK && popped != '0
            |-> count != CW'(spq_pkg::DEPTH))
        else $error("count full after pop");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
